// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: clocked property");

// Clocked property checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: unconditional property");

`endif

// File: rtl/b5gl_pkg.sv
// Constants for the Big5 glyph locator: code mapping and record geometry.
// No dependencies.
`timescale 1ns / 1ps

package b5gl_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned INDEX_W  = 14;
    localparam int unsigned OFFSET_W = 21;
    localparam int unsigned CODE_W   = 17;

    // Lead-byte thresholds and bases
    localparam logic [7:0] ASCII_MAX        = 8'd127;
    localparam logic [7:0] LEAD_DIRECT_LIM  = 8'd129;
    localparam logic [7:0] LEAD_SPLIT       = 8'd164;
    localparam logic [8:0] LOW_ROW_BASE     = 9'd161;
    localparam logic [8:0] HIGH_ROW_BASE    = 9'd164;
    localparam logic [7:0] TRAIL_FOLD_LIM   = 8'd161;
    localparam logic [7:0] TRAIL_FOLD_SHIFT = 8'd34;

    localparam logic signed [CODE_W-1:0] ROW_SPAN   = 17'sd157;
    localparam logic signed [CODE_W-1:0] TRAIL_BASE = 17'sd64;
    localparam logic signed [CODE_W-1:0] GAP_START  = 17'sd5809;
    localparam logic signed [CODE_W-1:0] GAP_SIZE   = 17'sd408;

    localparam logic [OFFSET_W-1:0] FULL_RECORD_BYTES = 21'd72;
    localparam logic [OFFSET_W-1:0] HALF_RECORD_BYTES = 21'd48;
    localparam logic [COORD_W-1:0]  FULL_ADVANCE      = 16'd24;
    localparam logic [COORD_W-1:0]  HALF_ADVANCE      = 16'd12;

    localparam logic [INDEX_W-1:0]  HALF_INDEX_LIM    = 14'd128;

endpackage

// File: rtl/b5gl_map.sv
// Big5 lead/trail pair to full-width font record index, with clamp flag.
// Depends on b5gl_pkg.
`timescale 1ns / 1ps

module b5gl_map (
    input  logic [b5gl_pkg::BYTE_W-1:0]  lead,
    input  logic [b5gl_pkg::BYTE_W-1:0]  trail,
    output logic [b5gl_pkg::INDEX_W-1:0] index,
    output logic                         neg
);
    import b5gl_pkg::*;

    logic signed [8:0]        row;
    logic [7:0]               trail_adj;
    logic signed [CODE_W-1:0] prod;
    logic signed [CODE_W-1:0] code;

    always_comb
    begin
        row       = '0;
        trail_adj = trail;
        if (lead < LEAD_SPLIT)
        begin
            row = $signed({1'b0, lead} - LOW_ROW_BASE);
        end
        else
        begin
            row = $signed({1'b0, lead} - HIGH_ROW_BASE);
            if (trail > TRAIL_FOLD_LIM)
            begin
                trail_adj = trail - TRAIL_FOLD_SHIFT;
            end
        end

        prod = CODE_W'(row) * ROW_SPAN;
        code = prod + $signed({9'd0, trail_adj}) - TRAIL_BASE;

        if (lead < LEAD_DIRECT_LIM)
        begin
            code = $signed({9'd0, lead});
        end
        else if (lead >= LEAD_SPLIT && code >= GAP_START)
        begin
            // close the unused block in the upper plane
            code = code - GAP_SIZE;
        end

        neg   = code[CODE_W-1];
        index = neg ? '0 : code[INDEX_W-1:0];
    end

endmodule

// File: rtl/big5_text_glyph_locator.sv
// Top level of the Big5 text glyph locator: cursor state, lead-byte hold,
// two-register result pipeline. Depends on b5gl_pkg and b5gl_map.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per transfer,
//   with line_start and the start position. line_start reloads the cursor
//   and drops a held lead byte. A zero byte ends the string and gives no
//   result. A byte above 127 with no lead held is held as a lead byte and
//   gives no result; the next nonzero byte completes a full-width glyph.
//   Output channel (out_valid/out_ready) carries one glyph: position, font
//   select, record index and byte offset, and the negative-code flag.
//   Pipeline: mapping and row multiply in the first register stage, record
//   size multiply in the second. Throughput: one byte per cycle while
//   in_ready is high, as the cursor and lead-byte registers update on
//   each accepted byte.
//   Reset clears the cursor to 0, drops any lead byte and empties the
//   pipeline. When the receiver stalls, the output register holds and the
//   first stage keeps taking bytes until it holds one more glyph; then
//   in_ready falls until the output register drains.
`timescale 1ns / 1ps

module big5_text_glyph_locator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [b5gl_pkg::BYTE_W-1:0]           text_byte,
    input  logic                                  line_start,
    input  logic signed [b5gl_pkg::COORD_W-1:0]   start_x,
    input  logic signed [b5gl_pkg::COORD_W-1:0]   start_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [b5gl_pkg::COORD_W-1:0]   glyph_x,
    output logic signed [b5gl_pkg::COORD_W-1:0]   glyph_y,
    output logic                                  wide_font,
    output logic [b5gl_pkg::INDEX_W-1:0]          record_index,
    output logic [b5gl_pkg::OFFSET_W-1:0]         record_offset,
    output logic                                  index_error
);
    import b5gl_pkg::*;

    // cursor and lead state
    logic                  lead_pending_reg, lead_pending_next;
    logic [BYTE_W-1:0]     lead_byte_reg, lead_byte_next;
    logic [COORD_W-1:0]    cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0]    cursor_y_reg, cursor_y_next;

    // first stage
    logic                  s1_valid_reg, s1_valid_next;
    logic [COORD_W-1:0]    s1_x_reg, s1_y_reg;
    logic                  s1_wide_reg, s1_err_reg;
    logic [INDEX_W-1:0]    s1_index_reg;

    // output stage
    logic                  out_valid_reg;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg;
    logic                  out_wide_reg, out_err_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [OFFSET_W-1:0]   out_offset_reg, out_offset_next;

    logic                  out_load;
    logic                  s1_load;
    logic                  accept;
    logic                  pending_eff;
    logic [COORD_W-1:0]    cur_x, cur_y;
    logic                  emit;
    logic                  emit_wide;
    logic [INDEX_W-1:0]    emit_index;
    logic                  map_neg;
    logic [INDEX_W-1:0]    map_index;

    b5gl_map u_map (
        .lead  (lead_byte_reg),
        .trail (text_byte),
        .index (map_index),
        .neg   (map_neg)
    );

    assign out_load = !out_valid_reg || out_ready;
    assign s1_load  = !s1_valid_reg || out_load;
    assign in_ready = s1_load;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pending_eff = lead_pending_reg && !line_start;
        cur_x       = line_start ? start_x : cursor_x_reg;
        cur_y       = line_start ? start_y : cursor_y_reg;

        lead_pending_next = pending_eff;
        lead_byte_next    = lead_byte_reg;
        cursor_x_next     = cur_x;
        cursor_y_next     = cur_y;
        emit              = 1'b0;
        emit_wide         = 1'b0;
        emit_index        = map_index;

        if (text_byte == '0)
        begin
            // end of string: drop any held lead byte
            lead_pending_next = 1'b0;
        end
        else if (pending_eff)
        begin
            lead_pending_next = 1'b0;
            emit              = 1'b1;
            emit_wide         = 1'b1;
            cursor_x_next     = cur_x + FULL_ADVANCE;
        end
        else if (text_byte > ASCII_MAX)
        begin
            lead_pending_next = 1'b1;
            lead_byte_next    = text_byte;
        end
        else
        begin
            emit          = 1'b1;
            emit_index    = INDEX_W'(text_byte);
            cursor_x_next = cur_x + HALF_ADVANCE;
        end

        s1_valid_next = accept && emit;
    end

    always_comb
    begin
        if (s1_wide_reg)
        begin
            out_offset_next = OFFSET_W'(s1_index_reg) * FULL_RECORD_BYTES;
        end
        else
        begin
            out_offset_next = OFFSET_W'(s1_index_reg) * HALF_RECORD_BYTES;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
        end
        else if (accept)
        begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && s1_valid_next)
        begin
            s1_x_reg     <= cur_x;
            s1_y_reg     <= cur_y;
            s1_wide_reg  <= emit_wide;
            s1_err_reg   <= emit_wide && map_neg;
            s1_index_reg <= emit_index;
        end
        if (out_load && s1_valid_reg)
        begin
            out_x_reg      <= s1_x_reg;
            out_y_reg      <= s1_y_reg;
            out_wide_reg   <= s1_wide_reg;
            out_err_reg    <= s1_err_reg;
            out_index_reg  <= s1_index_reg;
            out_offset_reg <= out_offset_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign glyph_x       = out_x_reg;
    assign glyph_y       = out_y_reg;
    assign wide_font     = out_wide_reg;
    assign record_index  = out_index_reg;
    assign record_offset = out_offset_reg;
    assign index_error   = out_err_reg;

endmodule

// File: rtl/b5gl_checker.sv
// Port-level checks for the Big5 glyph locator, bound to the top level.
// Depends on b5gl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b5gl_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [b5gl_pkg::COORD_W-1:0]   glyph_x,
    input  logic signed [b5gl_pkg::COORD_W-1:0]   glyph_y,
    input  logic                                  wide_font,
    input  logic [b5gl_pkg::INDEX_W-1:0]          record_index,
    input  logic [b5gl_pkg::OFFSET_W-1:0]         record_offset,
    input  logic                                  index_error
);
    import b5gl_pkg::*;

    localparam int unsigned PAYLOAD_W = 2 * COORD_W + INDEX_W + OFFSET_W + 2;

    logic [OFFSET_W-1:0]  expect_offset;
    logic                 out_stall;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 half_ok;
    logic                 clamp_ok;

    assign expect_offset = wide_font ? OFFSET_W'(record_index) * FULL_RECORD_BYTES
                                     : OFFSET_W'(record_index) * HALF_RECORD_BYTES;
    assign out_stall     = out_valid && !out_ready;
    assign out_payload   = {glyph_x, glyph_y, wide_font, record_index, record_offset,
                            index_error};
    assign half_ok       = !index_error && record_index < HALF_INDEX_LIM
                           && record_index != '0;
    assign clamp_ok      = wide_font && record_index == '0;

    // a stalled result holds
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_stall |=> out_valid)

    `ASSERT_CLKD(a_data_hold, clk, rst_n, out_stall |=> $stable(out_payload))

    `ASSERT_CLKD(a_offset_match, clk, rst_n, out_valid |-> record_offset == expect_offset)

    `ASSERT_CLKD(a_half_range, clk, rst_n, out_valid && !wide_font |-> half_ok)

    `ASSERT_CLKD(a_err_clamp, clk, rst_n, out_valid && index_error |-> clamp_ok)

endmodule

bind big5_text_glyph_locator b5gl_checker u_checker (.*);
